// ===== rtl/core/rspe_pkg.sv =====
package rspe_pkg;

    localparam logic [8:0] GF_POLY      = 9'h11d;
    localparam logic [5:0] PARITY_RESET = 6'd10;

    // cell operation codes
    localparam logic [2:0] CELL_HOLD  = 3'd0;
    localparam logic [2:0] CELL_LOAD  = 3'd1;
    localparam logic [2:0] CELL_GEN   = 3'd2;
    localparam logic [2:0] CELL_STEP  = 3'd3;
    localparam logic [2:0] CELL_SHIFT = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] mult;
    } rspe_ctl_t;

    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        logic [8:0] v;
        v = {a, 1'b0};
        if (v[8]) begin
            v = v ^ GF_POLY;
        end
        return v[7:0];
    endfunction

endpackage

// ===== rtl/core/reed_solomon_parity_encoder_top.sv =====
// on the item marked last, the first of d parity items is offered in the next
// cycle and the rest follow, one per accepted cycle
// throughput: one data item per cycle while s_tready is high; no data is taken
// while parity shifts out, as the single remainder chain both absorbs data and
// shifts parity out; reset and every parity_length write rebuild the generator
// with s_tready low; reset sets parity_length to 10 and clears the remainder
module reed_solomon_parity_encoder_top
    import rspe_pkg::*;
#(
    parameter int MAX_PARITY = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [5:0] cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tlast,   // last_data
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // parity_byte
    output logic       m_tlast    // last_parity
);

    localparam int LW = $clog2(MAX_PARITY + 1);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_GEN  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [5:0]    len_reg, len_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [7:0]    root_reg, root_next;
    logic [LW-1:0] eff_len;
    rspe_ctl_t     ctl;

    logic [7:0] rem_link [0:MAX_PARITY];
    logic [7:0] gen_link [0:MAX_PARITY];

    // zero length acts as one, long lengths saturate
    always_comb begin
        if (len_reg == 6'd0) begin
            eff_len = LW'(1);
        end else if (int'(len_reg) > MAX_PARITY) begin
            eff_len = LW'(MAX_PARITY);
        end else begin
            eff_len = LW'(len_reg);
        end
    end

    assign rem_link[MAX_PARITY] = 8'h00;
    assign gen_link[MAX_PARITY] = 8'h00;

    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
        rspe_cell u_cell (
            .aclk    (aclk),
            .ctl     (ctl),
            .seed    (eff_len == LW'(j + 1)),
            .rem_in  (rem_link[j+1]),
            .gen_in  (gen_link[j+1]),
            .rem_out (rem_link[j]),
            .gen_out (gen_link[j])
        );
    end

    assign s_tready = (state_reg == ST_RUN) && !cfg_we;
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = rem_link[0];
    assign m_tlast  = (cnt_reg == LW'(1));

    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        root_next  = root_reg;
        ctl.op     = CELL_HOLD;
        ctl.mult   = 8'h00;
        if (cfg_we) begin
            len_next   = cfg_wdata;
            state_next = ST_LOAD;
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    ctl.op     = CELL_LOAD;
                    cnt_next   = eff_len;
                    root_next  = 8'h01;
                    state_next = ST_GEN;
                end
                ST_GEN: begin
                    // multiply by the next root (x - 2^i) each cycle
                    ctl.op    = CELL_GEN;
                    ctl.mult  = root_reg;
                    root_next = gf_xtime(root_reg);
                    cnt_next  = cnt_reg - LW'(1);
                    if (cnt_reg == LW'(1)) begin
                        state_next = ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (s_tvalid) begin
                        ctl.op   = CELL_STEP;
                        ctl.mult = s_tdata ^ rem_link[0];
                        if (s_tlast) begin
                            cnt_next   = eff_len;
                            state_next = ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    // shifting out also leaves the remainder cleared
                    if (m_tready) begin
                        ctl.op   = CELL_SHIFT;
                        cnt_next = cnt_reg - LW'(1);
                        if (cnt_reg == LW'(1)) begin
                            state_next = ST_RUN;
                        end
                    end
                end
                default: begin
                    state_next = ST_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            len_reg   <= PARITY_RESET;
            cnt_reg   <= '0;
            root_reg  <= 8'h01;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            root_reg  <= root_next;
        end
    end

endmodule

// ===== rtl/core/rspe_cell.sv =====
module rspe_cell
    import rspe_pkg::*;
(
    input  logic       aclk,
    input  rspe_ctl_t  ctl,
    input  logic       seed,
    input  logic [7:0] rem_in,
    input  logic [7:0] gen_in,
    output logic [7:0] rem_out,
    output logic [7:0] gen_out
);

    logic [7:0] rem_reg, rem_next;
    logic [7:0] gen_reg, gen_next;
    logic [7:0] prod;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 7; i >= 0; i--) begin
            acc = gf_xtime(acc);
            if (b[i]) begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

    // one multiplier, shared by generator build and remainder update
    assign prod = gf_mul(gen_reg, ctl.mult);

    always_comb begin
        rem_next = rem_reg;
        gen_next = gen_reg;
        case (ctl.op)
            CELL_LOAD: begin
                rem_next = 8'h00;
                gen_next = {7'b0, seed};
            end
            CELL_GEN: begin
                gen_next = prod ^ gen_in;
            end
            CELL_STEP: begin
                rem_next = rem_in ^ prod;
            end
            CELL_SHIFT: begin
                rem_next = rem_in;
            end
            default: begin
                rem_next = rem_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        gen_reg <= gen_next;
    end

    assign rem_out = rem_reg;
    assign gen_out = gen_reg;

endmodule

// ===== dv/tb_reed_solomon_parity_encoder_top.sv =====
`timescale 1ns / 100ps

module tb_reed_solomon_parity_encoder_top;
    import rspe_pkg::*;

    localparam int          MAX_PAR     = 32;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [7:0] value;
        logic       tail;
    } parity_item_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [5:0] cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // data_byte
    logic       s_tlast;   // last_data
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // parity_byte
    logic       m_tlast;   // last_parity

    // encoder shadow state
    logic [7:0]   gen_coef [MAX_PAR];
    logic [7:0]   rem_reg  [MAX_PAR];
    int           eff_d;
    parity_item_t parity_expect_q [$];
    parity_item_t head_expect;

    int          err_cnt = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    logic        hold_req = 1'b0;
    int          hold_len = 0;
    int unsigned cycle_cnt;

    reed_solomon_parity_encoder_top #(
        .MAX_PARITY(MAX_PAR)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [7:0] gf_twice(input logic [7:0] a);
        logic [7:0] v;
        v = {a[6:0], 1'b0};
        if (a[7]) begin
            v = v ^ 8'h1d;
        end
        return v;
    endfunction

    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 7; k >= 0; k--) begin
            acc = gf_twice(acc);
            if (b[k]) begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

    // product of (x - 2^i) for i below d, leading one dropped
    task automatic load_generator(input logic [5:0] setting);
        int         d;
        logic [7:0] root;
        d = int'(setting);
        if (d < 1) begin
            d = 1;
        end
        if (d > MAX_PAR) begin
            d = MAX_PAR;
        end
        eff_d = d;
        for (int j = 0; j < MAX_PAR; j++) begin
            gen_coef[j] = 8'h00;
            rem_reg[j]  = 8'h00;
        end
        gen_coef[d - 1] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < d; i++) begin
            for (int j = 0; j < d; j++) begin
                gen_coef[j] = gf_times(gen_coef[j], root);
                if (j + 1 < d) begin
                    gen_coef[j] = gen_coef[j] ^ gen_coef[j + 1];
                end
            end
            root = gf_twice(root);
        end
    endtask

    task automatic absorb_byte(input logic [7:0] data, input logic last);
        logic [7:0]   factor;
        parity_item_t item;
        factor = data ^ rem_reg[0];
        for (int j = 0; j + 1 < eff_d; j++) begin
            rem_reg[j] = rem_reg[j + 1];
        end
        rem_reg[eff_d - 1] = 8'h00;
        for (int j = 0; j < eff_d; j++) begin
            rem_reg[j] = rem_reg[j] ^ gf_times(gen_coef[j], factor);
        end
        if (last) begin
            for (int j = 0; j < eff_d; j++) begin
                item.value = rem_reg[j];
                item.tail  = (j + 1 == eff_d);
                parity_expect_q = {parity_expect_q, item};
                rem_reg[j] = 8'h00;
            end
        end
    endtask

    task automatic feed_byte(input logic [7:0] data, input logic last);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = data;
        s_tlast  = last;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        absorb_byte(data, last);
    endtask

    task automatic feed_block(input int len);
        for (int k = 0; k < len; k++) begin
            feed_byte(8'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    task automatic drain_parity();
        while (parity_expect_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic program_parity_length(input logic [5:0] setting);
        // withdraw the offer before draining so the last item is not taken twice
        @(negedge aclk);
        s_tvalid = 1'b0;
        drain_parity();
        // let a trailing data item settle in the remainder chain
        repeat (MAX_PAR + 4) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = setting;
        @(negedge aclk);
        cfg_we = 1'b0;
        load_generator(setting);
    endtask

    function automatic logic [5:0] pick_length();
        case ($urandom_range(3))
            0: return 6'($urandom_range(0, 63));
            1: return 6'($urandom_range(1, 8));
            default: return 6'($urandom_range(1, 32));
        endcase
    endfunction

    task automatic test_reset_length();
        feed_byte(8'h00, 1'b1);
        feed_byte(8'hff, 1'b0);
        feed_byte(8'h00, 1'b0);
        feed_byte(8'h80, 1'b0);
        feed_byte(8'h01, 1'b1);
    endtask

    task automatic test_length_extremes();
        program_parity_length(6'd1);
        feed_byte(8'h5a, 1'b0);
        feed_byte(8'hff, 1'b1);
        program_parity_length(6'd32);
        feed_byte(8'hff, 1'b0);
        feed_byte(8'h55, 1'b0);
        feed_byte(8'haa, 1'b1);
        // zero behaves as one parity byte
        program_parity_length(6'd0);
        feed_byte(8'h7f, 1'b1);
        // above the maximum saturates
        program_parity_length(6'd63);
        feed_byte(8'h81, 1'b1);
        program_parity_length(6'd33);
        feed_byte(8'h01, 1'b1);
    endtask

    task automatic test_abandoned_block();
        program_parity_length(6'd7);
        feed_byte(8'h12, 1'b0);
        feed_byte(8'hed, 1'b0);
        feed_byte(8'h3c, 1'b0);
        // write mid block throws away the partial remainder
        program_parity_length(6'd5);
        feed_byte(8'hc3, 1'b0);
        feed_byte(8'h99, 1'b1);
    endtask

    task automatic test_random_phase(input int n_items, input int idle, input int stall);
        int sent;
        int len;
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        for (int sub = 0; sub < 2; sub++) begin
            program_parity_length(pick_length());
            sent = 0;
            while (sent < n_items / 2) begin
                len = $urandom_range(1, 12);
                feed_block(len);
                sent += len;
            end
        end
    endtask

    task automatic test_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        program_parity_length(6'd32);
        hold_len = 400;
        hold_req = 1'b1;
        for (int b = 0; b < 4; b++) begin
            feed_block(5);
        end
    endtask

    // result side ready, with a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (hold_len) @(negedge aclk);
            end
            m_tready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (parity_expect_q.size() == 0) begin
                $display("%0t unexpected parity item: got %02h last %0b",
                         $time, m_tdata, m_tlast);
                err_cnt++;
            end else begin
                head_expect = parity_expect_q.pop_front();
                if (m_tdata !== head_expect.value) begin
                    $display("%0t parity_byte mismatch: expected %02h, actual %02h",
                             $time, head_expect.value, m_tdata);
                    err_cnt++;
                end
                if (m_tlast !== head_expect.tail) begin
                    $display("%0t last_parity mismatch: expected %0b, actual %0b",
                             $time, head_expect.tail, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 6'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        load_generator(PARITY_RESET);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_length();
        test_length_extremes();
        test_abandoned_block();
        test_random_phase(100, 0, 0);
        test_random_phase(100, 88, 0);
        test_random_phase(100, 0, 88);
        test_random_phase(100, 28, 28);
        test_backpressure();

        @(negedge aclk);
        s_tvalid = 1'b0;
        drain_parity();
        repeat (MAX_PAR + 8) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rspe_pkg.sv
rtl/core/rspe_cell.sv
rtl/core/reed_solomon_parity_encoder_top.sv
dv/tb_reed_solomon_parity_encoder_top.sv
